// ===== src/tcpf_pkg.sv =====
// Package: states, command, reason and register codes for the TCP packet filter.
`timescale 1ns / 1ps
`default_nettype none
package tcpf_pkg;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_RD0,
    ST_VER,
    ST_FETCH,
    ST_DRAIN,
    ST_CHECK,
    ST_SCAN,
    ST_CLEAR
  } state_e;

  localparam int unsigned CONNECTIONS_DEF = 16;
  localparam int unsigned SERVICES_DEF    = 4;

  localparam logic [2:0] CMD_PKT   = 3'd0;
  localparam logic [2:0] CMD_SVC4  = 3'd1;
  localparam logic [2:0] CMD_SVC6  = 3'd2;
  localparam logic [2:0] CMD_PEER4 = 3'd3;
  localparam logic [2:0] CMD_PEER6 = 3'd4;

  localparam logic [2:0] RSN_PASS    = 3'd0;
  localparam logic [2:0] RSN_BOTH    = 3'd1;
  localparam logic [2:0] RSN_FAMILY  = 3'd2;
  localparam logic [2:0] RSN_VERSION = 3'd3;
  localparam logic [2:0] RSN_SHORT   = 3'd4;
  localparam logic [2:0] RSN_NOT_TCP = 3'd5;
  localparam logic [2:0] RSN_NO_SVC  = 3'd6;
  localparam logic [2:0] RSN_PEER    = 3'd7;

  localparam logic [2:0] CFG_PRESENT = 3'd0;
  localparam logic [2:0] CFG_DROP_V4 = 3'd1;
  localparam logic [2:0] CFG_DROP_V6 = 3'd2;
  localparam logic [2:0] CFG_TCP     = 3'd3;
  localparam logic [2:0] CFG_MATCH   = 3'd4;

  localparam logic [15:0] HDR_KEEP   = 16'd80;
  localparam logic [15:0] LEN_MAX    = 16'hFFFF;
  localparam logic [3:0]  VER_V4     = 4'd4;
  localparam logic [3:0]  VER_V6     = 4'd6;
  localparam logic [7:0]  PROTO_TCP  = 8'd6;
  localparam logic [4:0]  FETCH_LAST = 5'd22;

endpackage
`default_nettype wire

// ===== src/tcp_connection_packet_filter.sv =====
// Top level: TCP connection packet filter with sequenced header fetch and peer scan.
`timescale 1ns / 1ps
`default_nettype none
// Items enter on start_i while busy_o is low. cmd_i selects a packet byte or a
// service / peer table write. Commands and packet bytes that are not last leave
// busy_o low. The last byte of a packet starts the verdict: the header memory is
// read one byte a cycle; in match mode the peer table of the matched service is
// then scanned one memory word a cycle, unless the packet is SYN-only.
// The single read port of the header memory and of the peer memories sets these
// rates. busy_o stays high until the result is shown.
// The result (pass_packet_o, drop_reason_o) is on the ports for one cycle with
// valid_o high; the receiver cannot stall it.
// The user must write the configuration registers over cfg_valid_i / cfg_ready_o
// only while idle; the block itself does not enforce this.
// Reset clears the registers, the byte count and the service slots, then runs a
// clearing pass over the peer memories with busy_o high, so that unwritten
// peers read as zero.
module tcp_connection_packet_filter #(
  parameter int unsigned CONNECTIONS = tcpf_pkg::CONNECTIONS_DEF,
  parameter int unsigned SERVICES    = tcpf_pkg::SERVICES_DEF
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        start_i,
  output logic             busy_o,
  input  wire logic [2:0]  cmd_i,
  input  wire logic [7:0]  pkt_byte_i,
  input  wire logic        pkt_last_i,
  input  wire logic [1:0]  service_slot_i,
  input  wire logic [3:0]  peer_index_i,
  input  wire logic [15:0] port_value_i,
  input  wire logic        entry_valid_i,
  input  wire logic [31:0] addr_word_i,
  input  wire logic [1:0]  word_select_i,
  output logic             valid_o,
  output logic             pass_packet_o,
  output logic [2:0]       drop_reason_o,
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic [2:0]  cfg_index_i,
  input  wire logic        cfg_data_i
);
  import tcpf_pkg::*;

  localparam int unsigned NPEER = SERVICES * CONNECTIONS;
  localparam int unsigned PW    = (NPEER > 1) ? $clog2(NPEER) : 1;
  localparam int unsigned SW    = (SERVICES > 1) ? $clog2(SERVICES) : 1;
  localparam int unsigned CW    = (CONNECTIONS > 1) ? $clog2(CONNECTIONS) : 1;
  localparam int unsigned CLW   = PW + 2;

  state_e state_q, state_d;

  logic cfg_present_q, cfg_dv4_q, cfg_dv6_q, cfg_tcp_q, cfg_match_q;

  logic        acc;
  logic [15:0] count_q, count_inc;
  logic [15:0] len_q;

  logic [7:0]  hdr_mem [HDR_KEEP];
  logic [6:0]  hdr_raddr;
  logic [7:0]  hdr_rd_q;

  logic [3:0]   ver_q, ihl_q;
  logic [7:0]   proto_q, flags_q;
  logic [15:0]  dport_q, sport_q;
  logic [127:0] addr_q;
  logic [4:0]   f_q;
  logic [4:0]   cap_idx_q;
  logic         cap_vld_q;
  logic [6:0]   t_off, fetch_addr;

  logic [16:0] svc4_q [SERVICES];
  logic [16:0] svc6_q [SERVICES];
  logic          svc_hit;
  logic [SW-1:0] svc_idx, svc_q;
  logic [16:0]   svc_ent;

  logic          ok_peer;
  logic [PW-1:0] wr_ent, rd_ent;

  logic [47:0] pv4_mem  [NPEER];
  logic [31:0] pv6w_mem [NPEER*4];
  logic [15:0] pv6p_mem [NPEER];
  logic [47:0] pv4_rd_q;
  logic [31:0] pv6w_rd_q;
  logic [15:0] pv6p_rd_q;

  logic           clr_on;
  logic [CLW-1:0] clr_q;

  logic [CW-1:0] i_q;
  logic [1:0]    w_q, cmp_w_q;
  logic          iss_done_q, cmp_vld_q, cmp_laste_q, acc6_q;
  logic          is_v4, i_last;
  logic [3:0][31:0] addr_words;
  logic [47:0] pv4_data;
  logic [31:0] pv6w_data;
  logic [15:0] pv6p_data;
  logic        weq, acc_now, hit4, hit6, scan_end;

  logic       chk_done;
  logic [2:0] chk_rsn;
  logic       syn_only;

  logic       res_fire;
  logic [2:0] res_code;
  logic       res_vld_q, res_pass_q;
  logic [2:0] res_rsn_q;

  assign busy_o        = (state_q != ST_IDLE);
  assign acc           = start_i && !busy_o;
  assign cfg_ready_o   = 1'b1;
  assign valid_o       = res_vld_q;
  assign pass_packet_o = res_pass_q;
  assign drop_reason_o = res_rsn_q;

  // configuration
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_present_q <= 1'b0;
      cfg_dv4_q     <= 1'b0;
      cfg_dv6_q     <= 1'b0;
      cfg_tcp_q     <= 1'b0;
      cfg_match_q   <= 1'b0;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_PRESENT: cfg_present_q <= cfg_data_i;
        CFG_DROP_V4: cfg_dv4_q     <= cfg_data_i;
        CFG_DROP_V6: cfg_dv6_q     <= cfg_data_i;
        CFG_TCP:     cfg_tcp_q     <= cfg_data_i;
        CFG_MATCH:   cfg_match_q   <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // byte count
  assign count_inc = (count_q == LEN_MAX) ? count_q : count_q + 16'd1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else if (acc && cmd_i == CMD_PKT) begin
      count_q <= pkt_last_i ? '0 : count_inc;
    end
  end

  always_ff @(posedge clk_i) begin
    if (acc && cmd_i == CMD_PKT && pkt_last_i) begin
      len_q <= count_inc;
    end
  end

  // header memory
  always_ff @(posedge clk_i) begin
    if (acc && cmd_i == CMD_PKT && count_q < HDR_KEEP) begin
      hdr_mem[count_q[6:0]] <= pkt_byte_i;
    end
    hdr_rd_q <= hdr_mem[hdr_raddr];
  end

  assign t_off = (ver_q == VER_V4) ? {1'b0, ihl_q, 2'b00} : 7'd40;

  always_comb begin
    case (f_q)
      5'd1:    fetch_addr = (ver_q == VER_V4) ? 7'd9 : 7'd6;
      5'd2:    fetch_addr = t_off + 7'd13;
      5'd3:    fetch_addr = t_off + 7'd2;
      5'd4:    fetch_addr = t_off + 7'd3;
      5'd5:    fetch_addr = t_off;
      5'd6:    fetch_addr = t_off + 7'd1;
      default: fetch_addr = {2'b00, f_q} + 7'd1;
    endcase
  end

  assign hdr_raddr = (state_q == ST_FETCH) ? fetch_addr : '0;

  // header field capture
  always_ff @(posedge clk_i) begin
    if (state_q == ST_VER) begin
      ver_q <= hdr_rd_q[7:4];
      ihl_q <= hdr_rd_q[3:0];
    end
    if (cap_vld_q) begin
      case (cap_idx_q)
        5'd1:    proto_q        <= hdr_rd_q;
        5'd2:    flags_q        <= hdr_rd_q;
        5'd3:    dport_q[15:8]  <= hdr_rd_q;
        5'd4:    dport_q[7:0]   <= hdr_rd_q;
        5'd5:    sport_q[15:8]  <= hdr_rd_q;
        5'd6:    sport_q[7:0]   <= hdr_rd_q;
        default: addr_q         <= {addr_q[119:0], hdr_rd_q};
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      f_q       <= '0;
      cap_idx_q <= '0;
      cap_vld_q <= 1'b0;
    end else begin
      cap_vld_q <= (state_q == ST_FETCH);
      cap_idx_q <= f_q;
      if (state_q == ST_VER) begin
        f_q <= 5'd1;
      end else if (state_q == ST_FETCH) begin
        f_q <= f_q + 5'd1;
      end
    end
  end

  // service slots
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int s = 0; s < SERVICES; s++) begin
        svc4_q[s] <= '0;
        svc6_q[s] <= '0;
      end
    end else if (acc) begin
      for (int s = 0; s < SERVICES; s++) begin
        if (32'(service_slot_i) == s) begin
          if (cmd_i == CMD_SVC4) svc4_q[s] <= {entry_valid_i, port_value_i};
          if (cmd_i == CMD_SVC6) svc6_q[s] <= {entry_valid_i, port_value_i};
        end
      end
    end
  end

  always_comb begin
    svc_hit = 1'b0;
    svc_idx = '0;
    svc_ent = '0;
    for (int s = SERVICES - 1; s >= 0; s--) begin
      svc_ent = (ver_q == VER_V4) ? svc4_q[s] : svc6_q[s];
      if (svc_ent[16] && svc_ent[15:0] == dport_q) begin
        svc_hit = 1'b1;
        svc_idx = SW'(s);
      end
    end
  end

  // peer tables, zeroed by the clearing pass after reset
  assign clr_on  = (state_q == ST_CLEAR);
  assign ok_peer = (32'(service_slot_i) < SERVICES) && (32'(peer_index_i) < CONNECTIONS);
  assign wr_ent  = PW'(32'(service_slot_i) * CONNECTIONS + 32'(peer_index_i));
  assign rd_ent  = PW'(32'(svc_q) * CONNECTIONS + 32'(i_q));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q <= '0;
    end else if (clr_on) begin
      clr_q <= clr_q + CLW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (clr_on) begin
      pv4_mem[clr_q[CLW-1:2]] <= '0;
    end else if (acc && ok_peer && cmd_i == CMD_PEER4) begin
      pv4_mem[wr_ent] <= {addr_word_i, port_value_i};
    end
    pv4_rd_q <= pv4_mem[rd_ent];
  end

  always_ff @(posedge clk_i) begin
    if (clr_on) begin
      pv6w_mem[clr_q] <= '0;
    end else if (acc && ok_peer && cmd_i == CMD_PEER6) begin
      pv6w_mem[{wr_ent, word_select_i}] <= addr_word_i;
    end
    pv6w_rd_q <= pv6w_mem[{rd_ent, w_q}];
  end

  always_ff @(posedge clk_i) begin
    if (clr_on) begin
      pv6p_mem[clr_q[CLW-1:2]] <= '0;
    end else if (acc && ok_peer && cmd_i == CMD_PEER6) begin
      pv6p_mem[wr_ent] <= port_value_i;
    end
    pv6p_rd_q <= pv6p_mem[rd_ent];
  end

  // peer scan compare
  assign is_v4      = (ver_q == VER_V4);
  assign i_last     = (32'(i_q) == CONNECTIONS - 1);
  assign addr_words = addr_q;
  assign pv4_data   = pv4_rd_q;
  assign pv6w_data  = pv6w_rd_q;
  assign pv6p_data  = pv6p_rd_q;
  assign weq        = (pv6w_data == addr_words[~cmp_w_q]);
  assign acc_now    = ((cmp_w_q == 2'd0) ? 1'b1 : acc6_q) && weq;
  assign hit4       = cmp_vld_q && is_v4 && (pv4_data == {addr_q[95:64], sport_q});
  assign hit6       = cmp_vld_q && !is_v4 && (cmp_w_q == 2'd3) && acc_now
                      && (pv6p_data == sport_q);
  assign scan_end   = cmp_vld_q && cmp_laste_q && (is_v4 || cmp_w_q == 2'd3);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      i_q         <= '0;
      w_q         <= '0;
      iss_done_q  <= 1'b0;
      cmp_vld_q   <= 1'b0;
      cmp_w_q     <= '0;
      cmp_laste_q <= 1'b0;
      acc6_q      <= 1'b0;
      svc_q       <= '0;
    end else if (state_q == ST_SCAN) begin
      cmp_vld_q   <= !iss_done_q;
      cmp_w_q     <= w_q;
      cmp_laste_q <= i_last;
      if (cmp_vld_q) acc6_q <= acc_now;
      if (!iss_done_q) begin
        if (is_v4) begin
          if (i_last) iss_done_q <= 1'b1;
          else        i_q        <= i_q + CW'(1);
        end else begin
          w_q <= w_q + 2'd1;
          if (w_q == 2'd3) begin
            if (i_last) iss_done_q <= 1'b1;
            else        i_q        <= i_q + CW'(1);
          end
        end
      end
    end else begin
      i_q        <= '0;
      w_q        <= '0;
      iss_done_q <= 1'b0;
      cmp_vld_q  <= 1'b0;
      if (state_q == ST_CHECK) svc_q <= svc_idx;
    end
  end

  // verdict before the service lookup
  always_comb begin
    chk_done = 1'b1;
    chk_rsn  = RSN_PASS;
    if (!cfg_present_q) begin
      chk_rsn = RSN_PASS;
    end else if (cfg_dv4_q && cfg_dv6_q) begin
      chk_rsn = RSN_BOTH;
    end else if (!cfg_match_q && !cfg_tcp_q) begin
      if ((cfg_dv4_q && ver_q == VER_V4) || (cfg_dv6_q && ver_q == VER_V6)) begin
        chk_rsn = RSN_FAMILY;
      end
    end else if (ver_q == VER_V4) begin
      if (cfg_dv4_q)                                  chk_rsn = RSN_FAMILY;
      else if (len_q < 16'd20)                        chk_rsn = RSN_SHORT;
      else if (proto_q != PROTO_TCP)                  chk_rsn = RSN_NOT_TCP;
      else if (len_q < {9'd0, t_off} + 16'd20)        chk_rsn = RSN_SHORT;
      else if (cfg_match_q)                           chk_done = 1'b0;
    end else if (ver_q == VER_V6) begin
      if (cfg_dv6_q)                                  chk_rsn = RSN_FAMILY;
      else if (len_q < 16'd40)                        chk_rsn = RSN_SHORT;
      else if (proto_q != PROTO_TCP)                  chk_rsn = RSN_NOT_TCP;
      else if (len_q < 16'd60)                        chk_rsn = RSN_SHORT;
      else if (cfg_match_q)                           chk_done = 1'b0;
    end else begin
      chk_rsn = RSN_VERSION;
    end
  end

  assign syn_only = flags_q[1] && !flags_q[4];

  // sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= ST_CLEAR;
    else         state_q <= state_d;
  end

  always_comb begin
    state_d  = state_q;
    res_fire = 1'b0;
    res_code = RSN_PASS;
    case (state_q)
      ST_CLEAR: begin
        if (32'(clr_q) == NPEER * 4 - 1) state_d = ST_IDLE;
      end
      ST_IDLE: begin
        if (acc && cmd_i == CMD_PKT && pkt_last_i) state_d = ST_RD0;
      end
      ST_RD0:  state_d = ST_VER;
      ST_VER:  state_d = ST_FETCH;
      ST_FETCH: begin
        if (f_q == FETCH_LAST) state_d = ST_DRAIN;
      end
      ST_DRAIN: state_d = ST_CHECK;
      ST_CHECK: begin
        if (chk_done) begin
          res_fire = 1'b1;
          res_code = chk_rsn;
          state_d  = ST_IDLE;
        end else if (!svc_hit) begin
          res_fire = 1'b1;
          res_code = RSN_NO_SVC;
          state_d  = ST_IDLE;
        end else if (syn_only) begin
          res_fire = 1'b1;
          res_code = RSN_PASS;
          state_d  = ST_IDLE;
        end else begin
          state_d = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (hit4 || hit6) begin
          res_fire = 1'b1;
          res_code = RSN_PASS;
          state_d  = ST_IDLE;
        end else if (scan_end) begin
          res_fire = 1'b1;
          res_code = RSN_PEER;
          state_d  = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_vld_q <= 1'b0;
    end else begin
      res_vld_q <= res_fire;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_fire) begin
      res_rsn_q  <= res_code;
      res_pass_q <= (res_code == RSN_PASS);
    end
  end

endmodule
`default_nettype wire
